// File: src/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Request line tokenizer package
// Shared types, character codes and helpers for the tokenizer modules.
// ----------------------------------------------------------------------------
package rlt_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam int LEN_W = 9;
	localparam logic [LEN_W-1:0] LEN_SAT = 9'd256;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [1:0] TOK_METHOD  = 2'd0;
	localparam logic [1:0] TOK_PATH    = 2'd1;
	localparam logic [1:0] TOK_VERSION = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [1:0] id;
		logic [7:0] tbyte;
		logic [7:0] idx;
		logic       bad;
		logic       last;
	} result_t;

	// One job holds the one or two results of one accepted byte.
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} job_t;

	function automatic logic [7:0] sat_idx(input logic [LEN_W-1:0] len);
		sat_idx = len[LEN_W-1] ? 8'hFF : len[7:0];
	endfunction

	function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] len);
		len_inc = (len == LEN_SAT) ? len : len + 9'd1;
	endfunction

	function automatic logic [1:0] tok_of(input logic [1:0] spaces);
		tok_of = spaces[1] ? TOK_VERSION : spaces;
	endfunction

endpackage

// File: src/rlt_front.sv
// ----------------------------------------------------------------------------
// Request line tokenizer front end
// Classifies each accepted byte, updates line state and builds a result job when one is due.
// ----------------------------------------------------------------------------
module rlt_front #(
	parameter int METHOD_CAP  = 16,
	parameter int PATH_CAP    = 256,
	parameter int VERSION_CAP = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     data_byte,
	input  logic           end_of_buffer,
	output logic           job_valid,
	output rlt_pkg::job_t  job
);
	import rlt_pkg::*;

	localparam logic [LEN_W-1:0] M_CAP = LEN_W'(METHOD_CAP);
	localparam logic [LEN_W-1:0] P_CAP = LEN_W'(PATH_CAP);
	localparam logic [LEN_W-1:0] V_CAP = LEN_W'(VERSION_CAP);

	logic             done_q;
	logic             held_q;
	logic [1:0]       spaces_q;
	logic [LEN_W-1:0] len_q;
	logic             bad_q;

	logic             done_d;
	logic             held_d;
	logic [1:0]       spaces_d;
	logic [LEN_W-1:0] len_d;
	logic             bad_d;

	logic [LEN_W-1:0] len_a;
	logic [LEN_W-1:0] cap_sel;
	logic             verdict_bad;
	result_t          r_cr;
	result_t          r_byte;
	result_t          r_verdict;

	always_comb begin
		len_a   = held_q ? len_inc(len_q) : len_q;
		cap_sel = (spaces_q == 2'd0) ? M_CAP : P_CAP;
		verdict_bad = bad_q || (spaces_q != 2'd2) || (len_q == '0) || (len_q >= V_CAP);

		r_cr      = '{kind: KIND_BYTE, id: tok_of(spaces_q), tbyte: CH_CR,
			idx: sat_idx(len_q), bad: 1'b0, last: 1'b0};
		r_byte    = '{kind: KIND_BYTE, id: tok_of(spaces_q), tbyte: data_byte,
			idx: sat_idx(len_a), bad: 1'b0, last: 1'b1};
		r_verdict = '{kind: KIND_VERDICT, id: TOK_METHOD, tbyte: 8'h00,
			idx: 8'h00, bad: 1'b1, last: 1'b1};

		done_d   = done_q;
		held_d   = held_q;
		spaces_d = spaces_q;
		len_d    = len_q;
		bad_d    = bad_q;
		job_valid = 1'b0;
		job = '{two: 1'b0, first: r_verdict, second: r_byte};

		if (!done_q) begin
			priority if (held_q && data_byte == CH_LF) begin
				job_valid = 1'b1;
				job.first.bad = verdict_bad;
				held_d = 1'b0;
				done_d = 1'b1;
			end else if (end_of_buffer) begin
				job_valid = 1'b1;
			end else begin
				held_d = 1'b0;
				len_d  = len_a;
				// a held CR becomes content ahead of this byte
				if (held_q) begin
					job_valid = 1'b1;
					job.first = r_cr;
					job.first.last = 1'b1;
				end
				priority if (data_byte == CH_CR) begin
					held_d = 1'b1;
				end else if (data_byte == CH_SP) begin
					if (!spaces_q[1] && (len_a == '0 || len_a >= cap_sel))
						bad_d = 1'b1;
					if (spaces_q != 2'd3)
						spaces_d = spaces_q + 2'd1;
					len_d = '0;
				end else begin
					len_d = len_inc(len_a);
					job_valid = 1'b1;
					if (held_q) begin
						job.two = 1'b1;
						job.first.last = 1'b0;
					end else begin
						job.first = r_byte;
					end
				end
			end
		end

		if (!accept)
			job_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			held_q   <= 1'b0;
			spaces_q <= 2'd0;
			len_q    <= '0;
			bad_q    <= 1'b0;
		end else if (accept) begin
			if (end_of_buffer) begin
				done_q   <= 1'b0;
				held_q   <= 1'b0;
				spaces_q <= 2'd0;
				len_q    <= '0;
				bad_q    <= 1'b0;
			end else begin
				done_q   <= done_d;
				held_q   <= held_d;
				spaces_q <= spaces_d;
				len_q    <= len_d;
				bad_q    <= bad_d;
			end
		end
	end

endmodule

// File: src/rlt_queue.sv
// ----------------------------------------------------------------------------
// Request line tokenizer job queue
// Short register queue between the front end and the result stage.
// ----------------------------------------------------------------------------
module rlt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  rlt_pkg::job_t  wr_job,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output rlt_pkg::job_t  rd_job
);
	import rlt_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             jobs_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W+1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = jobs_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			jobs_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/rlt_back.sv
// ----------------------------------------------------------------------------
// Request line tokenizer result stage
// Holds one job and hands out its results one beat at a time.
// ----------------------------------------------------------------------------
module rlt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  rlt_pkg::job_t     q_job,
	output logic              q_pop,
	output logic              empty,
	input  logic              pop,
	output rlt_pkg::result_t  res
);
	import rlt_pkg::*;

	job_t cur_q;
	logic valid_q;
	logic second_q;
	logic finish;
	logic load;

	assign finish = valid_q && pop && (!cur_q.two || second_q);
	assign load   = !valid_q || finish;
	assign q_pop  = load && q_valid;
	assign empty  = !valid_q;
	assign res    = second_q ? cur_q.second : cur_q.first;

	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= q_valid;
				second_q <= 1'b0;
			end else if (valid_q && pop) begin
				// advance to the second result of this job
				second_q <= 1'b1;
			end
		end
	end

	a_second_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (valid_q && cur_q.two))
		else $error("second result shown for a single-result job");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(second_q)))
		else $error("result stage moved without a pop");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && (!cur_q.two || second_q)) |-> res.last)
		else $error("final result of a job lacks the last mark");

endmodule

// File: src/request_line_tokenizer_top.sv
// A byte's results pass through the job queue and then the result stage register
// before they can be popped.
// Throughput: one byte per cycle in while full is low, one result beat per cycle
// out while jobs wait. A content byte right after a held CR gives two beats.
// full is set by the four-entry job queue between front end and result stage.
// Reset: arst_n clears line state, the queue and the result stage at once.
// ----------------------------------------------------------------------------
// Request line tokenizer top level
// Splits the first line of a request buffer into method, path and version.
// ----------------------------------------------------------------------------
module request_line_tokenizer_top #(
	parameter int METHOD_CAP  = 16,
	parameter int PATH_CAP    = 256,
	parameter int VERSION_CAP = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output logic       empty,
	input  logic       pop,
	output logic       result_kind,
	output logic [1:0] token_id,
	output logic [7:0] token_byte,
	output logic [7:0] byte_index,
	output logic       line_bad,
	output logic       last_result
);
	import rlt_pkg::*;

	logic    accept;
	logic    job_valid;
	job_t    job;
	logic    q_valid;
	job_t    q_job;
	logic    q_pop;
	result_t res;

	assign accept = push && !full;

	rlt_front #(
		.METHOD_CAP  (METHOD_CAP),
		.PATH_CAP    (PATH_CAP),
		.VERSION_CAP (VERSION_CAP)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.job_valid     (job_valid),
		.job           (job)
	);

	rlt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_valid),
		.wr_job   (job),
		.full     (full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_job   (q_job)
	);

	rlt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign result_kind = res.kind;
	assign token_id    = res.id;
	assign token_byte  = res.tbyte;
	assign byte_index  = res.idx;
	assign line_bad    = res.bad;
	assign last_result = res.last;

endmodule

// File: verif/request_line_tokenizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Request line tokenizer testbench
// Feeds request buffers (short directed lines, then random well-formed and
// broken lines) through the push side, predicts every token byte and verdict
// in a software tokenizer, and checks each popped beat against the oldest
// prediction. Both sides idle at random; the pop side also holds off for one
// long stretch so that the job queue fills and full is exercised.
// ----------------------------------------------------------------------------
module request_line_tokenizer_top_tb;

	import rlt_pkg::*;

	localparam int METHOD_CAP  = 16;
	localparam int PATH_CAP    = 256;
	localparam int VERSION_CAP = 16;

	localparam int RANDOM_BYTES = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 20;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		logic [7:0] data;
		logic       eob;
	} in_beat_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       push          = 1'b0;
	logic       pop           = 1'b0;
	logic [7:0] data_byte     = 8'h00;
	logic       end_of_buffer = 1'b0;
	logic       full;
	logic       empty;
	logic       result_kind;
	logic [1:0] token_id;
	logic [7:0] token_byte;
	logic [7:0] byte_index;
	logic       line_bad;
	logic       last_result;

	in_beat_t pending_bytes[$];
	result_t  expected_results[$];

	int n_items;
	int n_accepted = 0;
	int errors     = 0;
	int cycles     = 0;
	int gap_left   = 0;
	int burst_left = 0;
	int mode_left  = 0;
	int pop_pct    = 100;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	// tokenizer state as predicted
	logic             line_done = 1'b0;
	logic             cr_held   = 1'b0;
	logic             line_err  = 1'b0;
	logic [1:0]       n_spaces  = 2'd0;
	logic [LEN_W-1:0] tok_len   = '0;

	request_line_tokenizer_top #(
		.METHOD_CAP  (METHOD_CAP),
		.PATH_CAP    (PATH_CAP),
		.VERSION_CAP (VERSION_CAP)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.empty         (empty),
		.pop           (pop),
		.result_kind   (result_kind),
		.token_id      (token_id),
		.token_byte    (token_byte),
		.byte_index    (byte_index),
		.line_bad      (line_bad),
		.last_result   (last_result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_LIMIT)
			$display("ERROR @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int token_cap(input logic [1:0] id);
		if (id == TOK_METHOD) return METHOD_CAP;
		if (id == TOK_PATH) return PATH_CAP;
		return VERSION_CAP;
	endfunction

	// One content byte of the current token; advances the token length.
	function automatic result_t token_beat(input logic [7:0] b);
		result_t r;
		r.kind  = KIND_BYTE;
		r.id    = (n_spaces > 2'd2) ? TOK_VERSION : n_spaces;
		r.tbyte = b;
		r.idx   = (tok_len > 255) ? 8'hFF : tok_len[7:0];
		r.bad   = 1'b0;
		r.last  = 1'b0;
		if (tok_len < LEN_SAT)
			tok_len = tok_len + 1'b1;
		return r;
	endfunction

	task automatic tokenize_byte(input logic [7:0] b, input logic eob);
		result_t r[2];
		int      k;
		k = 0;
		if (!line_done) begin
			if (cr_held && b == CH_LF) begin
				r[0] = '{kind: KIND_VERDICT, id: TOK_METHOD, tbyte: 8'h00, idx: 8'h00,
					bad: line_err || n_spaces != 2'd2 || tok_len == 0 ||
					tok_len >= VERSION_CAP, last: 1'b0};
				k = 1;
				cr_held = 1'b0;
				line_done = 1'b1;
			end else if (eob) begin
				// buffer ended inside the line: only a bad verdict
				r[0] = '{kind: KIND_VERDICT, id: TOK_METHOD, tbyte: 8'h00, idx: 8'h00,
					bad: 1'b1, last: 1'b0};
				k = 1;
			end else begin
				if (cr_held) begin
					cr_held = 1'b0;
					r[k] = token_beat(CH_CR);
					k++;
				end
				if (b == CH_CR) begin
					cr_held = 1'b1;
				end else if (b == CH_SP) begin
					if (n_spaces < 2'd2 && (tok_len == 0 || tok_len >= token_cap(n_spaces)))
						line_err = 1'b1;
					if (n_spaces < 2'd3)
						n_spaces = n_spaces + 2'd1;
					tok_len = '0;
				end else begin
					r[k] = token_beat(b);
					k++;
				end
			end
		end
		for (int i = 0; i < k; i++) begin
			r[i].last = (i == k - 1);
			expected_results.push_back(r[i]);
		end
		if (eob) begin
			line_done = 1'b0;
			cr_held   = 1'b0;
			line_err  = 1'b0;
			n_spaces  = 2'd0;
			tok_len   = '0;
		end
	endtask

	task automatic add_byte(input logic [7:0] b, input logic eob);
		pending_bytes.push_back('{data: b, eob: eob});
	endtask

	task automatic add_text(input string s, input bit eob_last);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], eob_last && i == s.len() - 1);
	endtask

	// Token content: never a space or LF; now and then a lone CR.
	function automatic logic [7:0] token_char();
		logic [7:0] c;
		if ($urandom_range(0, 23) == 0)
			return CH_CR;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_SP || c == CH_CR || c == CH_LF);
		return c;
	endfunction

	task automatic add_token(input int len);
		for (int i = 0; i < len; i++)
			add_byte(token_char(), 1'b0);
	endtask

	// Short lengths mostly, with the cap boundaries and the empty token mixed in.
	function automatic int short_len();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return 15;
			2: return 16;
			3: return 17;
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic int path_len();
		case ($urandom_range(0, 79))
			0: return 0;
			1: return $urandom_range(255, 256);
			2: return $urandom_range(257, 300);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	// Driver: bursts of offered beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			data_byte <= 8'h00;
			end_of_buffer <= 1'b0;
		end else begin
			if (push && !full) begin
				tokenize_byte(data_byte, end_of_buffer);
				void'(pending_bytes.pop_front());
				n_accepted++;
			end
			if (push && full) begin
				// hold the beat until it is taken
			end else if (gap_left != 0 || pending_bytes.size() == 0) begin
				push <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end else begin
				push <= 1'b1;
				data_byte <= pending_bytes[0].data;
				end_of_buffer <= pending_bytes[0].eob;
				if (burst_left != 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
	end

	// Long pop hold-off once the run is well under way.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= 400) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check each popped beat, stall on a changing pop rate.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("beat with nothing pending: kind %0b byte %02h",
						result_kind, token_byte));
				end else begin
					want = expected_results.pop_front();
					if (result_kind !== want.kind)
						report_mismatch($sformatf("result_kind %0b, want %0b",
							result_kind, want.kind));
					if (token_id !== want.id)
						report_mismatch($sformatf("token_id %0d, want %0d", token_id, want.id));
					if (token_byte !== want.tbyte)
						report_mismatch($sformatf("token_byte %02h, want %02h",
							token_byte, want.tbyte));
					if (byte_index !== want.idx)
						report_mismatch($sformatf("byte_index %0d, want %0d",
							byte_index, want.idx));
					if (line_bad !== want.bad)
						report_mismatch($sformatf("line_bad %0b, want %0b", line_bad, want.bad));
					if (last_result !== want.last)
						report_mismatch($sformatf("last_result %0b, want %0b",
							last_result, want.last));
				end
			end
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: pop_pct = 100;
					1: pop_pct = 70;
					2: pop_pct = 35;
					default: pop_pct = 10;
				endcase
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			pop <= (hold_left == 0) && ($urandom_range(0, 99) < pop_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ERROR: timeout, %0d of %0d bytes taken, %0d beats pending",
				n_accepted, n_items, expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int n;
		int tail;
		logic [7:0] c;

		// well-formed line, then ignored bytes with a buffer end among them
		add_text("M / V\r\n", 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b1);
		// CR held then another CR: first goes out as content
		add_text("\r\r\n", 1'b0);
		add_byte("A", 1'b1);
		// empty path, buffer ends while a CR is held
		add_text("a  b\r", 1'b0);
		add_byte("x", 1'b1);
		// three spaces, line end on the buffer's last byte
		add_text("   z\r", 1'b0);
		add_byte(CH_LF, 1'b1);

		while (pending_bytes.size() < 25 + RANDOM_BYTES) begin
			if ($urandom_range(0, 9) < 7) begin
				add_token(short_len());
				add_byte(CH_SP, 1'b0);
				add_token(path_len());
				add_byte(CH_SP, 1'b0);
				add_token(short_len());
				if ($urandom_range(0, 15) == 0) begin
					add_byte(CH_SP, 1'b0);
					add_token($urandom_range(1, 4));
				end
				if ($urandom_range(0, 9) == 0) begin
					// no line end before the buffer ends
					add_byte(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					add_byte(CH_CR, 1'b0);
					tail = $urandom_range(0, 3);
					add_byte(CH_LF, tail == 0);
					for (int i = 1; i <= tail; i++)
						add_byte(8'($urandom_range(0, 255)), i == tail);
				end
			end else begin
				n = $urandom_range(1, 16);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(0, 5))
						0: c = CH_SP;
						1: c = CH_CR;
						2: c = CH_LF;
						default: c = 8'($urandom_range(0, 255));
					endcase
					add_byte(c, i == n - 1);
				end
			end
		end
		n_items = pending_bytes.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_items)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
src/rlt_pkg.sv
src/rlt_front.sv
src/rlt_queue.sv
src/rlt_back.sv
src/request_line_tokenizer_top.sv
verif/request_line_tokenizer_top_tb.sv
